// ===== hdl/spq_pkg.sv =====
package spq_pkg;

   localparam int DEPTH_DEF     = 16;
   localparam int ITEM_BITS_DEF = 32;
   localparam int PRIO_BITS_DEF = 16;

   localparam int CMD_BITS    = 2;
   localparam int RANK_BITS   = 4;
   localparam int STATUS_BITS = 2;

   typedef enum logic [CMD_BITS-1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_READ   = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_COMPARE,
      FSM_COMMIT
   } fsm_type;

   typedef struct packed {
      logic load;
      logic compare;
      logic commit;
   } ctrl_type;

endpackage

// ===== hdl/spq_req_if.sv =====
interface spq_req_if
   import spq_pkg::*;
#(
   parameter int ITEM_BITS = ITEM_BITS_DEF,
   parameter int PRIO_BITS = PRIO_BITS_DEF
);
   logic                        valid;
   logic                        ready;
   logic [CMD_BITS-1:0]         cmd;
   logic [ITEM_BITS-1:0]        item_key;
   logic signed [PRIO_BITS-1:0] prio_in;
   logic [RANK_BITS-1:0]        rank;

   modport source (output valid, cmd, item_key, prio_in, rank, input ready);
   modport sink   (input valid, cmd, item_key, prio_in, rank, output ready);
endinterface

// ===== hdl/spq_rsp_if.sv =====
interface spq_rsp_if
   import spq_pkg::*;
#(
   parameter int ITEM_BITS  = ITEM_BITS_DEF,
   parameter int PRIO_BITS  = PRIO_BITS_DEF,
   parameter int COUNT_BITS = $clog2(DEPTH_DEF + 1)
);
   logic                        valid;
   logic                        ready;
   logic [STATUS_BITS-1:0]      status;
   logic [ITEM_BITS-1:0]        read_item;
   logic signed [PRIO_BITS-1:0] read_prio;
   logic [COUNT_BITS-1:0]       entry_count;

   modport source (output valid, status, read_item, read_prio, entry_count, input ready);
   modport sink   (input valid, status, read_item, read_prio, entry_count, output ready);
endinterface

// ===== hdl/spq_ctrl.sv =====
module spq_ctrl
   import spq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output ctrl_type ctrl
);

   fsm_type state_ff, state_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ctrl         = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         FSM_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.load = 1'b1;
               state_in  = FSM_COMPARE;
            end
         end
         FSM_COMPARE: begin
            ctrl.compare = 1'b1;
            state_in     = FSM_COMMIT;
         end
         FSM_COMMIT: begin
            // hold until the previous beat has left the output register
            if (slot_free) begin
               ctrl.commit  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("commit while output register occupied");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == FSM_COMMIT))
      else $error("response raised without a commit");

   a_accept_compare: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == FSM_COMPARE))
      else $error("accepted beat did not enter compare");

   a_compare_commit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_COMPARE) |=> (state_ff == FSM_COMMIT))
      else $error("compare not followed by commit");

endmodule

// ===== hdl/spq_datapath.sv =====
module spq_datapath
   import spq_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int ITEM_BITS  = ITEM_BITS_DEF,
   parameter int PRIO_BITS  = PRIO_BITS_DEF,
   parameter int COUNT_BITS = $clog2(DEPTH + 1)
)(
   input  logic                        clock,
   input  logic                        reset,
   input  ctrl_type                    ctrl,
   input  logic [CMD_BITS-1:0]         req_cmd,
   input  logic [ITEM_BITS-1:0]        req_item_key,
   input  logic signed [PRIO_BITS-1:0] req_prio_in,
   input  logic [RANK_BITS-1:0]        req_rank,
   output logic [STATUS_BITS-1:0]      rsp_status,
   output logic [ITEM_BITS-1:0]        rsp_read_item,
   output logic signed [PRIO_BITS-1:0] rsp_read_prio,
   output logic [COUNT_BITS-1:0]       rsp_entry_count
);

   localparam int IDX_BITS = $clog2(DEPTH);
   localparam int LVL      = $clog2(DEPTH);
   localparam int RW       = (IDX_BITS > RANK_BITS) ? IDX_BITS : RANK_BITS;
   localparam int MW       = ((RW > COUNT_BITS) ? RW : COUNT_BITS) + 1;

   op_type                      cmd_ff;
   logic [ITEM_BITS-1:0]        key_ff;
   logic signed [PRIO_BITS-1:0] prio_ff;
   logic [RANK_BITS-1:0]        rank_ff;

   logic [ITEM_BITS-1:0]        cell_item_ff [DEPTH];
   logic signed [PRIO_BITS-1:0] cell_prio_ff [DEPTH];
   logic [ITEM_BITS-1:0]        cell_item_in [DEPTH];
   logic signed [PRIO_BITS-1:0] cell_prio_in [DEPTH];

   logic [DEPTH-1:0]            flag_ff, flag_in;
   logic [DEPTH-1:0]            pfx [LVL+1];

   logic [COUNT_BITS-1:0]       count_ff, count_in;
   logic [STATUS_BITS-1:0]      status_ff, status_in;
   logic [ITEM_BITS-1:0]        read_item_ff, read_item_in;
   logic signed [PRIO_BITS-1:0] read_prio_ff, read_prio_in;

   logic                        full, found, rank_hit;
   logic [MW-1:0]               rank_ext;
   logic [IDX_BITS-1:0]         rank_idx;

   // command capture
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff  <= op_type'(req_cmd);
         key_ff  <= req_item_key;
         prio_ff <= req_prio_in;
         rank_ff <= req_rank;
      end
   end

   // per-cell compare: priority order for insert, key match for delete
   for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
      localparam logic [COUNT_BITS-1:0] POS = COUNT_BITS'(i);
      always_comb begin
         if (cmd_ff == OP_INSERT)
            flag_in[i] = (POS < count_ff) && (cell_prio_ff[i] <= prio_ff);
         else
            flag_in[i] = (POS < count_ff) && (cell_item_ff[i] == key_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.compare) flag_ff <= flag_in;
   end

   // inclusive prefix OR of the match flags, log-depth
   assign pfx[0] = flag_ff;
   for (genvar l = 0; l < LVL; l++) begin : g_lvl
      for (genvar i = 0; i < DEPTH; i++) begin : g_bit
         if (i >= (1 << l)) begin : g_or
            assign pfx[l+1][i] = pfx[l][i] | pfx[l][i-(1<<l)];
         end else begin : g_pass
            assign pfx[l+1][i] = pfx[l][i];
         end
      end
   end

   assign full  = (count_ff == COUNT_BITS'(DEPTH));
   assign found = pfx[LVL][DEPTH-1];

   // cell next values: shift up behind the insert point, down over the deleted one
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic open_here;
      logic [ITEM_BITS-1:0]        up_item, dn_item;
      logic signed [PRIO_BITS-1:0] up_prio, dn_prio;
      if (i == 0) begin : g_first
         assign open_here = 1'b1;
         assign up_item   = cell_item_ff[i];
         assign up_prio   = cell_prio_ff[i];
      end else begin : g_rest
         assign open_here = flag_ff[i-1];
         assign up_item   = cell_item_ff[i-1];
         assign up_prio   = cell_prio_ff[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign dn_item = cell_item_ff[i];
         assign dn_prio = cell_prio_ff[i];
      end else begin : g_mid
         assign dn_item = cell_item_ff[i+1];
         assign dn_prio = cell_prio_ff[i+1];
      end
      always_comb begin
         cell_item_in[i] = cell_item_ff[i];
         cell_prio_in[i] = cell_prio_ff[i];
         case (cmd_ff)
            OP_INSERT: begin
               if (!full && !flag_ff[i]) begin
                  if (open_here) begin
                     cell_item_in[i] = key_ff;
                     cell_prio_in[i] = prio_ff;
                  end else begin
                     cell_item_in[i] = up_item;
                     cell_prio_in[i] = up_prio;
                  end
               end
            end
            OP_DELETE: begin
               if (pfx[LVL][i]) begin
                  cell_item_in[i] = dn_item;
                  cell_prio_in[i] = dn_prio;
               end
            end
            default: ;
         endcase
      end
      always_ff @(posedge clock) begin
         if (ctrl.commit) begin
            cell_item_ff[i] <= cell_item_in[i];
            cell_prio_ff[i] <= cell_prio_in[i];
         end
      end
   end

   assign rank_ext = MW'(rank_ff);
   assign rank_hit = rank_ext < MW'(count_ff);
   assign rank_idx = rank_ext[IDX_BITS-1:0];

   always_comb begin
      count_in     = count_ff;
      status_in    = ST_OK;
      read_item_in = '0;
      read_prio_in = '0;
      case (cmd_ff)
         OP_INSERT: begin
            if (full) status_in = ST_FULL;
            else      count_in  = count_ff + COUNT_BITS'(1);
         end
         OP_DELETE: begin
            if (found) count_in  = count_ff - COUNT_BITS'(1);
            else       status_in = ST_NOTFOUND;
         end
         OP_READ: begin
            if (rank_hit) begin
               read_item_in = cell_item_ff[rank_idx];
               read_prio_in = cell_prio_ff[rank_idx];
            end else begin
               status_in = ST_EMPTY;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctrl.commit) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.commit) begin
         status_ff    <= status_in;
         read_item_ff <= read_item_in;
         read_prio_ff <= read_prio_in;
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_read_item   = read_item_ff;
   assign rsp_read_prio   = read_prio_ff;
   // count moves only on commit, and commit waits for the output slot
   assign rsp_entry_count = count_ff;

endmodule

// ===== hdl/sorted_priority_queue_unit.sv =====
// channel  | dir | handshake    | payload
// req_ch   | in  | valid/ready  | cmd, item_key, prio_in, rank
// rsp_ch   | out | valid/ready  | status, read_item, read_prio, entry_count
//
// Each command passes through accept, a parallel compare across all cells,
// then a commit that shifts the cell row and loads the output register.
// A new command is accepted only once the previous one has committed.
// Reset empties the queue; cell contents are not cleared.
// A stalled response holds the commit of the following command, not its accept.
module sorted_priority_queue_unit
   import spq_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEF,
   parameter int ITEM_BITS = ITEM_BITS_DEF,
   parameter int PRIO_BITS = PRIO_BITS_DEF
)(
   input  logic       clock,
   input  logic       reset,
   spq_req_if.sink    req_ch,
   spq_rsp_if.source  rsp_ch
);

   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   ctrl_type ctrl;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .ctrl      (ctrl)
   );

   spq_datapath #(
      .DEPTH      (DEPTH),
      .ITEM_BITS  (ITEM_BITS),
      .PRIO_BITS  (PRIO_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .req_cmd         (req_ch.cmd),
      .req_item_key    (req_ch.item_key),
      .req_prio_in     (req_ch.prio_in),
      .req_rank        (req_ch.rank),
      .rsp_status      (rsp_ch.status),
      .rsp_read_item   (rsp_ch.read_item),
      .rsp_read_prio   (rsp_ch.read_prio),
      .rsp_entry_count (rsp_ch.entry_count)
   );

endmodule

// ===== tb/sorted_priority_queue_unit_tb.sv =====
module sorted_priority_queue_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import spq_pkg::*;

   localparam int DEPTH       = DEPTH_DEF;
   localparam int ITEM_BITS   = ITEM_BITS_DEF;
   localparam int PRIO_BITS   = PRIO_BITS_DEF;
   localparam int COUNT_BITS  = $clog2(DEPTH_DEF + 1);
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int LONG_HOLD   = 400;
   localparam int PHASE_BEATS = 200;

   typedef logic [ITEM_BITS-1:0]        item_t;
   typedef logic signed [PRIO_BITS-1:0] prio_t;
   typedef logic [RANK_BITS-1:0]        rank_t;
   typedef logic [COUNT_BITS-1:0]       count_t;

   typedef struct {
      status_type status;
      item_t      item;
      prio_t      prio;
      count_t     count;
   } queue_result_t;

   // Shadow copy of the sorted store; front of the queues is rank 0.
   class queue_shadow;
      item_t         held_item[$];
      prio_t         held_prio[$];
      queue_result_t awaited[$];
      int            failures;

      function void note_command(op_type op, item_t key, prio_t prio, rank_t rank);
         queue_result_t r;
         int            pos;
         r.status = ST_OK;
         r.item   = '0;
         r.prio   = '0;
         pos      = 0;
         case (op)
            OP_INSERT: begin
               if (held_item.size() >= DEPTH) begin
                  r.status = ST_FULL;
               end else begin
                  // place after every entry of equal or lower priority
                  while (pos < held_item.size() && held_prio[pos] <= prio) pos++;
                  held_item.insert(pos, key);
                  held_prio.insert(pos, prio);
               end
            end
            OP_DELETE: begin
               while (pos < held_item.size() && held_item[pos] != key) pos++;
               if (pos == held_item.size()) begin
                  r.status = ST_NOTFOUND;
               end else begin
                  held_item.delete(pos);
                  held_prio.delete(pos);
               end
            end
            OP_READ: begin
               if (rank < held_item.size()) begin
                  r.item = held_item[rank];
                  r.prio = held_prio[rank];
               end else begin
                  r.status = ST_EMPTY;
               end
            end
            default: ;
         endcase
         r.count = COUNT_BITS'(held_item.size());
         awaited.push_back(r);
      endfunction

      function void check_response(status_type status, item_t item, prio_t prio,
                                   count_t count);
         queue_result_t r;
         if (awaited.size() == 0) begin
            $error("response beat with nothing awaited: status %0d", status);
            failures++;
            return;
         end
         r = awaited.pop_front();
         if (status !== r.status) begin
            $error("status: expected %0d, actual %0d", r.status, status);
            failures++;
         end
         if (item !== r.item) begin
            $error("read_item: expected %h, actual %h", r.item, item);
            failures++;
         end
         if (prio !== r.prio) begin
            $error("read_prio: expected %0d, actual %0d", r.prio, prio);
            failures++;
         end
         if (count !== r.count) begin
            $error("entry_count: expected %0d, actual %0d", r.count, count);
            failures++;
         end
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   bit   steady_phase;
   bit   long_hold_request;
   int   cycle_count;

   queue_shadow shadow = new();

   spq_req_if req_ch ();
   spq_rsp_if rsp_ch ();

   sorted_priority_queue_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            shadow.note_command(op_type'(req_ch.cmd), req_ch.item_key, req_ch.prio_in,
                                req_ch.rank);
         if (rsp_ch.valid && rsp_ch.ready)
            shadow.check_response(status_type'(rsp_ch.status), rsp_ch.read_item,
                                  rsp_ch.read_prio, rsp_ch.entry_count);
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_phase || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Mostly a small key pool so deletes find their targets.
   function automatic item_t pick_key();
      if ($urandom_range(0, 99) < 80) return item_t'($urandom_range(0, 23));
      return item_t'($urandom());
   endfunction

   function automatic prio_t pick_prio();
      int r;
      int small_prio;
      r = $urandom_range(0, 99);
      small_prio = int'($urandom_range(0, 8)) - 4;
      if (r < 50) return prio_t'(small_prio);
      if (r < 90) return prio_t'($urandom());
      case ($urandom_range(0, 3))
         0: return prio_t'(16'sh8000);
         1: return prio_t'(16'sh7fff);
         2: return prio_t'(0);
         default: return prio_t'(-1);
      endcase
   endfunction

   // Response side: random ready, with one long hold on request.
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
   end

   // Drive one command beat; returns on the falling edge after acceptance.
   task automatic send_command(op_type op, item_t key, prio_t prio, rank_t rank);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.cmd      <= op;
      req_ch.item_key <= key;
      req_ch.prio_in  <= prio;
      req_ch.rank     <= rank;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random(bit filling);
      int     r;
      op_type op;
      r = $urandom_range(0, 99);
      if (r < (filling ? 55 : 20)) op = OP_INSERT;
      else if (r < (filling ? 75 : 70)) op = OP_DELETE;
      else if (r < 97) op = OP_READ;
      else op = OP_NOP;
      send_command(op, pick_key(), pick_prio(), rank_t'($urandom_range(0, 15)));
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (shadow.awaited.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      int fill_key;
      req_ch.valid    = 1'b0;
      req_ch.cmd      = OP_NOP;
      req_ch.item_key = '0;
      req_ch.prio_in  = '0;
      req_ch.rank     = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty store: delete misses, read finds nothing, unused code is a no-op
      send_command(OP_DELETE, item_t'(32'h1234), prio_t'(0), rank_t'(0));
      send_command(OP_READ, '0, '0, rank_t'(0));
      send_command(OP_NOP, '1, '1, '1);
      // priority extremes and ties
      send_command(OP_INSERT, '1, prio_t'(16'sh7fff), rank_t'(0));
      send_command(OP_INSERT, '0, prio_t'(16'sh8000), rank_t'(0));
      send_command(OP_INSERT, item_t'(5), prio_t'(0), rank_t'(0));
      send_command(OP_INSERT, item_t'(6), prio_t'(0), rank_t'(0));
      send_command(OP_INSERT, item_t'(7), prio_t'(16'sh8000), rank_t'(0));
      send_command(OP_READ, '0, '0, rank_t'(0));
      send_command(OP_READ, '0, '0, rank_t'(4));
      send_command(OP_READ, '0, '0, rank_t'(15));
      // duplicate item: delete takes the one nearest the front
      send_command(OP_INSERT, item_t'(6), prio_t'(-1), rank_t'(0));
      send_command(OP_DELETE, item_t'(6), '0, rank_t'(0));
      send_command(OP_DELETE, item_t'(32'hdeadbeef), '0, rank_t'(0));
      fill_key = 100;
      while (shadow.held_item.size() < DEPTH) begin
         send_command(OP_INSERT, item_t'(fill_key), prio_t'(fill_key * 7 - 740),
                      rank_t'(0));
         fill_key++;
      end
      send_command(OP_INSERT, item_t'(32'h5a5a5a5a), prio_t'(1), rank_t'(0));
      send_command(OP_READ, '0, '0, rank_t'(15));
      send_command(OP_DELETE, '0, '0, rank_t'(0));
      wait_drained();

      // alternate filling and draining phases
      for (int phase = 0; phase < 8; phase++) begin
         steady_phase = (phase % 4 == 3);
         if (phase == 2) long_hold_request = 1'b1;
         repeat (PHASE_BEATS) send_random(phase % 2 == 0);
         if (phase % 3 == 1) wait_drained();
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (shadow.failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/spq_pkg.sv
hdl/spq_req_if.sv
hdl/spq_rsp_if.sv
hdl/spq_ctrl.sv
hdl/spq_datapath.sv
hdl/sorted_priority_queue_unit.sv
tb/sorted_priority_queue_unit_tb.sv
